// ----- rtl/stag_pkg.sv -----
package stag_pkg;

  // Screen and span limits
  localparam int SCREEN_WIDTH = 240;
  localparam int MAX_SPAN     = 128;

  // Position wrap
  localparam int X_WRAP  = 512;
  localparam int Y_LIMIT = 160;
  localparam int Y_WRAP  = 256;

  // Tile addressing
  localparam logic [16:0] VRAM_SPRITE_BASE = 17'h10000;
  localparam logic [9:0]  TILE_ROW_MASK    = 10'h3E0;
  localparam logic [9:0]  TILE_COL_MASK    = 10'h01F;
  localparam int          BITMAP_TILE_MIN  = 512;

  // Identity coefficient in 8.8
  localparam logic signed [15:0] COEF_ONE = 16'sh0100;

  // Sprite palettes sit in the upper half
  localparam logic [4:0] PALETTE_OBJ_BASE = 5'h10;

  typedef enum logic [1:0] {
    OBJ_NORMAL     = 2'd0,
    OBJ_SEMI_TRANS = 2'd1,
    OBJ_MASK       = 2'd2,
    OBJ_RESERVED   = 2'd3
  } obj_mode_t;

  typedef enum logic {
    REG_MAPPING_1D = 1'b0,
    REG_BITMAP     = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [31:0]        attr_low_word;
    logic [15:0]        attr_tile_word;
    logic signed [15:0] coef_pa;
    logic signed [15:0] coef_pb;
    logic signed [15:0] coef_pc;
    logic signed [15:0] coef_pd;
    logic [7:0]         scanline;
    logic [6:0]         pixel_offset;
  } stag_req_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [7:0]  screen_x;
    logic [16:0] tile_address;
    logic [2:0]  texel_column;
    logic [2:0]  texel_row;
    logic        eight_bpp;
    logic [4:0]  palette_bank;
    logic [1:0]  draw_priority;
    logic [1:0]  object_mode;
    logic        last_in_span;
  } stag_rsp_t;

  // Fields reported from the attributes whatever the validity
  typedef struct packed {
    logic       eight_bpp;
    logic [4:0] palette_bank;
    logic [1:0] draw_priority;
    logic [1:0] object_mode;
    logic       last_in_span;
  } stag_attr_t;

  // Sprite geometry carried down the pipe
  typedef struct packed {
    logic       ok;
    logic       fliph;
    logic       flipv;
    logic       is256;
    logic [6:0] width;
    logic [6:0] height;
    logic [9:0] tile;
    logic [7:0] screen_x;
  } stag_geom_t;

  typedef struct packed {
    logic               valid;
    stag_geom_t         geom;
    stag_attr_t         attr;
    logic signed [7:0]  lx;
    logic signed [7:0]  ly;
    logic signed [15:0] pa;
    logic signed [15:0] pb;
    logic signed [15:0] pc;
    logic signed [15:0] pd;
  } stag_s1_t;

  typedef struct packed {
    logic               valid;
    stag_geom_t         geom;
    stag_attr_t         attr;
    logic signed [23:0] pax;
    logic signed [23:0] pby;
    logic signed [23:0] pcx;
    logic signed [23:0] pdy;
  } stag_s2_t;

  typedef struct packed {
    logic       valid;
    stag_geom_t geom;
    stag_attr_t attr;
    logic [5:0] tx;
    logic [5:0] ty;
  } stag_s3_t;

  typedef struct packed {
    logic [6:0] w;
    logic [6:0] h;
  } stag_dims_t;

  // Sprite dimensions by shape and size; prohibited shape has none
  function automatic stag_dims_t stag_dims(input logic [1:0] shape, input logic [1:0] size);
    stag_dims_t d;
    d = '{w: 7'd0, h: 7'd0};
    case ({shape, size})
      4'b0000: d = '{w: 7'd8,  h: 7'd8};
      4'b0001: d = '{w: 7'd16, h: 7'd16};
      4'b0010: d = '{w: 7'd32, h: 7'd32};
      4'b0011: d = '{w: 7'd64, h: 7'd64};
      4'b0100: d = '{w: 7'd16, h: 7'd8};
      4'b0101: d = '{w: 7'd32, h: 7'd8};
      4'b0110: d = '{w: 7'd32, h: 7'd16};
      4'b0111: d = '{w: 7'd64, h: 7'd32};
      4'b1000: d = '{w: 7'd8,  h: 7'd16};
      4'b1001: d = '{w: 7'd8,  h: 7'd32};
      4'b1010: d = '{w: 7'd16, h: 7'd32};
      4'b1011: d = '{w: 7'd32, h: 7'd64};
      default: d = '{w: 7'd0, h: 7'd0};
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/stag_decode.sv -----
module stag_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                req_valid,
  input  stag_pkg::stag_req_t req,
  output stag_pkg::stag_s1_t  s1
);

  logic [31:0]        a;
  logic               affine;
  logic               dbl;
  logic [1:0]         mode;
  stag_pkg::stag_dims_t dims;
  logic [5:0]         half_w;
  logic [5:0]         half_h;
  logic [6:0]         hw;
  logic [6:0]         hh;
  logic [7:0]         span;
  logic [7:0]         offset8;
  logic signed [10:0] x_s;
  logic signed [9:0]  y_s;
  logic signed [9:0]  cy;
  logic signed [10:0] ly;
  logic signed [10:0] hh_s;
  logic signed [11:0] gx;
  logic signed [8:0]  lx;
  logic               early_ok;
  logic               line_ok;
  logic               screen_ok;
  stag_pkg::stag_s1_t s1_next;

  // Attribute decode, position wrap and centre-relative coordinates
  always_comb begin
    a       = req.attr_low_word;
    affine  = a[8];
    dbl     = a[9];
    mode    = a[11:10];
    dims    = stag_pkg::stag_dims(a[15:14], a[31:30]);
    half_w  = dims.w[6:1];
    half_h  = dims.h[6:1];
    hw      = (affine && dbl) ? {half_w, 1'b0} : {1'b0, half_w};
    hh      = (affine && dbl) ? {half_h, 1'b0} : {1'b0, half_h};
    span    = {hw, 1'b0};
    offset8 = {1'b0, req.pixel_offset};

    x_s = $signed({2'b00, a[24:16]});
    if (x_s >= 11'(stag_pkg::SCREEN_WIDTH)) begin
      x_s = x_s - 11'(stag_pkg::X_WRAP);
    end
    y_s = $signed({2'b00, a[7:0]});
    if (y_s >= 10'(stag_pkg::Y_LIMIT)) begin
      y_s = y_s - 10'(stag_pkg::Y_WRAP);
    end

    cy   = y_s + $signed({3'b000, hh});
    ly   = $signed({3'b000, req.scanline}) - $signed({cy[9], cy});
    hh_s = $signed({4'b0000, hh});
    gx   = $signed({x_s[10], x_s}) + $signed({5'b00000, req.pixel_offset});
    lx   = $signed({2'b00, req.pixel_offset}) - $signed({2'b00, hw});

    early_ok  = !(!affine && dbl) && (mode != stag_pkg::OBJ_RESERVED)
                && (offset8 < span)
                && ({2'b00, req.pixel_offset} < 9'(stag_pkg::MAX_SPAN));
    line_ok   = (ly >= -hh_s) && (ly < hh_s);
    screen_ok = (gx >= 12'sd0) && (gx < 12'(stag_pkg::SCREEN_WIDTH));

    s1_next.valid          = req_valid;
    s1_next.geom.ok        = early_ok && line_ok && screen_ok;
    s1_next.geom.fliph     = !affine && a[28];
    s1_next.geom.flipv     = !affine && a[29];
    s1_next.geom.is256     = a[13];
    s1_next.geom.width     = dims.w;
    s1_next.geom.height    = dims.h;
    s1_next.geom.tile      = req.attr_tile_word[9:0];
    s1_next.geom.screen_x  = gx[7:0];

    s1_next.attr.eight_bpp     = a[13];
    s1_next.attr.palette_bank  = stag_pkg::PALETTE_OBJ_BASE + {1'b0, req.attr_tile_word[15:12]};
    s1_next.attr.draw_priority = req.attr_tile_word[11:10];
    s1_next.attr.object_mode   = (mode == stag_pkg::OBJ_RESERVED) ? stag_pkg::OBJ_NORMAL : mode;
    s1_next.attr.last_in_span  = (hw != 7'd0) && (offset8 == span - 8'd1);

    // Valid pixels keep both offsets within one signed byte
    s1_next.lx = lx[7:0];
    s1_next.ly = ly[7:0];
    s1_next.pa = affine ? req.coef_pa : stag_pkg::COEF_ONE;
    s1_next.pb = affine ? req.coef_pb : 16'sd0;
    s1_next.pc = affine ? req.coef_pc : 16'sd0;
    s1_next.pd = affine ? req.coef_pd : stag_pkg::COEF_ONE;
  end

  // Stage register: valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (en) begin
      s1.valid <= s1_next.valid;
    end
  end

  // Stage register: payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1.geom <= s1_next.geom;
      s1.attr <= s1_next.attr;
      s1.lx   <= s1_next.lx;
      s1.ly   <= s1_next.ly;
      s1.pa   <= s1_next.pa;
      s1.pb   <= s1_next.pb;
      s1.pc   <= s1_next.pc;
      s1.pd   <= s1_next.pd;
    end
  end

endmodule

// ----- rtl/stag_affine.sv -----
module stag_affine (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  stag_pkg::stag_s1_t s1,
  output stag_pkg::stag_s2_t s2
);

  stag_pkg::stag_s2_t s2_next;

  // Four matrix products, 16 by 8 signed
  always_comb begin
    s2_next.valid = s1.valid;
    s2_next.geom  = s1.geom;
    s2_next.attr  = s1.attr;
    s2_next.pax   = 24'(s1.pa) * 24'(s1.lx);
    s2_next.pby   = 24'(s1.pb) * 24'(s1.ly);
    s2_next.pcx   = 24'(s1.pc) * 24'(s1.lx);
    s2_next.pdy   = 24'(s1.pd) * 24'(s1.ly);
  end

  // Stage register: valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (en) begin
      s2.valid <= s2_next.valid;
    end
  end

  // Stage register: payload
  always_ff @(posedge clk) begin
    if (en) begin
      s2.geom <= s2_next.geom;
      s2.attr <= s2_next.attr;
      s2.pax  <= s2_next.pax;
      s2.pby  <= s2_next.pby;
      s2.pcx  <= s2_next.pcx;
      s2.pdy  <= s2_next.pdy;
    end
  end

endmodule

// ----- rtl/stag_texel.sv -----
module stag_texel (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  stag_pkg::stag_s2_t s2,
  output stag_pkg::stag_s3_t s3
);

  logic signed [24:0] sum_x;
  logic signed [24:0] sum_y;
  logic signed [17:0] tx_full;
  logic signed [17:0] ty_full;
  logic               tex_ok;
  logic [6:0]         tx_flip;
  logic [6:0]         ty_flip;
  stag_pkg::stag_s3_t s3_next;

  // Sum, floor shift by 8, recentre, texture bounds and flips
  always_comb begin
    sum_x   = $signed({s2.pax[23], s2.pax}) + $signed({s2.pby[23], s2.pby});
    sum_y   = $signed({s2.pcx[23], s2.pcx}) + $signed({s2.pdy[23], s2.pdy});
    tx_full = $signed({sum_x[24], sum_x[24:8]}) + $signed({12'd0, s2.geom.width[6:1]});
    ty_full = $signed({sum_y[24], sum_y[24:8]}) + $signed({12'd0, s2.geom.height[6:1]});
    tex_ok  = !tx_full[17] && !ty_full[17]
              && (tx_full[16:0] < {10'd0, s2.geom.width})
              && (ty_full[16:0] < {10'd0, s2.geom.height});
    tx_flip = s2.geom.width - {1'b0, tx_full[5:0]} - 7'd1;
    ty_flip = s2.geom.height - {1'b0, ty_full[5:0]} - 7'd1;

    s3_next.valid   = s2.valid;
    s3_next.geom    = s2.geom;
    s3_next.geom.ok = s2.geom.ok && tex_ok;
    s3_next.attr    = s2.attr;
    s3_next.tx      = s2.geom.fliph ? tx_flip[5:0] : tx_full[5:0];
    s3_next.ty      = s2.geom.flipv ? ty_flip[5:0] : ty_full[5:0];
  end

  // Stage register: valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      s3.valid <= 1'b0;
    end else if (en) begin
      s3.valid <= s3_next.valid;
    end
  end

  // Stage register: payload
  always_ff @(posedge clk) begin
    if (en) begin
      s3.geom <= s3_next.geom;
      s3.attr <= s3_next.attr;
      s3.tx   <= s3_next.tx;
      s3.ty   <= s3_next.ty;
    end
  end

endmodule

// ----- rtl/stag_tile.sv -----
module stag_tile (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                mapping_one_dimensional,
  input  logic                bitmap_display,
  input  stag_pkg::stag_s3_t  s3,
  output logic                rsp_valid,
  output stag_pkg::stag_rsp_t rsp
);

  logic [2:0]          bx;
  logic [2:0]          by;
  logic [3:0]          bx2;
  logic [4:0]          stride;
  logic [7:0]          row_off;
  logic [9:0]          tnum_1d;
  logic [9:0]          base_lo;
  logic [9:0]          tnum_2d;
  logic [9:0]          tnum;
  logic                ok;
  stag_pkg::stag_rsp_t rsp_next;

  // Tile number for linear or 32-wide mapping, bitmap block, result
  always_comb begin
    bx      = s3.tx[5:3];
    by      = s3.ty[5:3];
    bx2     = s3.geom.is256 ? {bx, 1'b0} : {1'b0, bx};
    stride  = s3.geom.is256 ? s3.geom.width[6:2] : {1'b0, s3.geom.width[6:3]};
    row_off = {5'd0, by} * {3'd0, stride};
    tnum_1d = s3.geom.tile + {2'd0, row_off} + {6'd0, bx2};
    base_lo = s3.geom.is256 ? {s3.geom.tile[9:1], 1'b0} : s3.geom.tile;
    tnum_2d = ((s3.geom.tile + {2'd0, by, 5'd0}) & stag_pkg::TILE_ROW_MASK)
              | ((base_lo + {6'd0, bx2}) & stag_pkg::TILE_COL_MASK);
    tnum    = mapping_one_dimensional ? tnum_1d : tnum_2d;
    ok      = s3.geom.ok
              && !(bitmap_display && ({1'b0, tnum} < 11'(stag_pkg::BITMAP_TILE_MIN)));

    rsp_next.pixel_valid   = ok;
    rsp_next.screen_x      = ok ? s3.geom.screen_x : 8'd0;
    rsp_next.tile_address  = ok ? (stag_pkg::VRAM_SPRITE_BASE + {2'd0, tnum, 5'd0}) : 17'd0;
    rsp_next.texel_column  = ok ? s3.tx[2:0] : 3'd0;
    rsp_next.texel_row     = ok ? s3.ty[2:0] : 3'd0;
    rsp_next.eight_bpp     = s3.attr.eight_bpp;
    rsp_next.palette_bank  = s3.attr.palette_bank;
    rsp_next.draw_priority = s3.attr.draw_priority;
    rsp_next.object_mode   = s3.attr.object_mode;
    rsp_next.last_in_span  = s3.attr.last_in_span;
  end

  // Output register: valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= s3.valid;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- rtl/sprite_texel_address_generator.sv -----
// Channel   Handshake              Payload           Role
// req       req_valid / req_stall  stag_req_t        one sprite pixel request
// rsp       rsp_valid / rsp_stall  stag_rsp_t        texel address and attributes
// apb       psel / penable / ...   pwdata / prdata   mapping and bitmap registers
//
// One request per cycle while rsp is not stalled; a result is presented on rsp
// after the decode, multiply and texel stages and the tile/output register.
// Reset clears every stage valid bit and both registers; no sweep after reset.
// A stall on a valid rsp freezes all four stages and stalls req in the same cycle.
module sprite_texel_address_generator (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  stag_pkg::stag_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output stag_pkg::stag_rsp_t rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic               mapping_one_dimensional;
  logic               bitmap_display;
  logic               advance;
  logic               cfg_write;
  stag_pkg::reg_index_t cfg_index;
  stag_pkg::stag_s1_t s1;
  stag_pkg::stag_s2_t s2;
  stag_pkg::stag_s3_t s3;

  // Whole pipe moves unless the output register is full and held
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = !advance;

  // Register port
  assign pready    = 1'b1;
  assign cfg_index = stag_pkg::reg_index_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mapping_one_dimensional <= 1'b0;
      bitmap_display          <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        stag_pkg::REG_MAPPING_1D: mapping_one_dimensional <= pwdata[0];
        stag_pkg::REG_BITMAP:     bitmap_display          <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      stag_pkg::REG_MAPPING_1D: prdata = {31'd0, mapping_one_dimensional};
      stag_pkg::REG_BITMAP:     prdata = {31'd0, bitmap_display};
      default:                  prdata = 32'd0;
    endcase
  end

  stag_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .req_valid (req_valid),
    .req       (req),
    .s1        (s1)
  );

  stag_affine u_affine (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .s1  (s1),
    .s2  (s2)
  );

  stag_texel u_texel (
    .clk (clk),
    .rst (rst),
    .en  (advance),
    .s2  (s2),
    .s3  (s3)
  );

  stag_tile u_tile (
    .clk                     (clk),
    .rst                     (rst),
    .en                      (advance),
    .mapping_one_dimensional (mapping_one_dimensional),
    .bitmap_display          (bitmap_display),
    .s3                      (s3),
    .rsp_valid               (rsp_valid),
    .rsp                     (rsp)
  );

endmodule
